FILE: rtl/svpdc_pkg.sv
`timescale 1ns / 1ps

package svpdc_pkg;

    localparam int VOLT_WIDTH_DEF = 16;

    // register file of the configuration channel
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DC_BUS_VOLTAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD   = 1'b1;
    localparam logic [CFG_DATA_W-1:0] DC_BUS_VOLTAGE_RST = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] TIMER_PERIOD_RST   = 16'd4199;

    // sqrt3 in Q15
    localparam int SQRT3_Q15 = 56756;

    // compare values, quotient of the divider
    localparam int CMP_W      = 16;
    localparam int DIV_W      = 2 * CMP_W;
    localparam int DIV_STAGES = CMP_W;

    localparam int SECTOR_W = 3;
    localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;
    localparam logic [SECTOR_W-1:0] SECTOR_6 = 3'd6;

    localparam int OUT_FIELDS_W = 3 * CMP_W + SECTOR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [CMP_W-1:0] rem;
        logic [CMP_W-1:0] low;
        logic [CMP_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [2:0]     lane;
        logic [SECTOR_W-1:0] sector;
    } div_word_t;

endpackage

FILE: rtl/svpwm_duty_compare.sv
`timescale 1ns / 1ps

// Space vector PWM compare generator. Each transfer on the s side carries an
// alpha/beta voltage pair; the block forms the three phase voltages, adds the
// min-max zero-sequence offset, turns each phase into a duty of the bus
// voltage around one half, clamps it to 0..1 and scales it by the timer
// period (truncating), and reports the sector 1..6 of the vector. A new pair
// is taken every clock cycle unless a stall on the m side has filled every
// stage; each result passes through five stages of transform, clamp and
// scaling, sixteen stages of the bit-per-stage divider by the bus voltage,
// and the output register. A stall on the m side holds every item in place,
// and empty stages keep filling while a result waits. Bus voltage and timer
// period are written on the cfg channel, which is always ready; write them
// only while no item is in flight. A bus voltage of zero acts as one.

module svpwm_duty_compare
    import svpdc_pkg::*;
#(
    parameter int VOLT_WIDTH = VOLT_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // alpha_voltage, beta_voltage
    input  logic [((2*VOLT_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // compare_a, compare_b, compare_c, sector
    output logic [OUT_TDATA_W-1:0]               m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data
);

    logic [CFG_DATA_W-1:0] dc_bus_reg;
    logic [CFG_DATA_W-1:0] timer_period_reg;
    logic [CFG_DATA_W-1:0] dc_bus_eff;

    logic                  ph_valid, ph_ready;
    logic [DIV_W-1:0]      prod_a, prod_b, prod_c;
    logic [SECTOR_W-1:0]   ph_sector;

    logic                  dv_valid, dv_ready;
    logic [CMP_W-1:0]      quot_a, quot_b, quot_c;
    logic [SECTOR_W-1:0]   dv_sector;

    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_bus_reg       <= DC_BUS_VOLTAGE_RST;
            timer_period_reg <= TIMER_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DC_BUS_VOLTAGE: dc_bus_reg       <= cfg_data;
                REG_TIMER_PERIOD:   timer_period_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign dc_bus_eff = (dc_bus_reg == '0) ? CFG_DATA_W'(1) : dc_bus_reg;

    svpdc_phase #(
        .VOLT_WIDTH (VOLT_WIDTH)
    ) u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .alpha_voltage (s_tdata[VOLT_WIDTH-1:0]),
        .beta_voltage  (s_tdata[2*VOLT_WIDTH-1:VOLT_WIDTH]),
        .dc_bus        (dc_bus_eff),
        .timer_period  (timer_period_reg),
        .out_valid     (ph_valid),
        .out_ready     (ph_ready),
        .prod_a        (prod_a),
        .prod_b        (prod_b),
        .prod_c        (prod_c),
        .sector        (ph_sector)
    );

    svpdc_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (ph_valid),
        .in_ready   (ph_ready),
        .dividend_a (prod_a),
        .dividend_b (prod_b),
        .dividend_c (prod_c),
        .sector_in  (ph_sector),
        .divisor    (dc_bus_eff),
        .out_valid  (dv_valid),
        .out_ready  (dv_ready),
        .quot_a     (quot_a),
        .quot_b     (quot_b),
        .quot_c     (quot_c),
        .sector_out (dv_sector)
    );

    assign dv_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (dv_ready)
            m_tvalid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready && dv_valid)
            m_tdata_reg <= OUT_TDATA_W'({dv_sector, quot_c, quot_b, quot_a});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/svpdc_phase.sv
`timescale 1ns / 1ps

module svpdc_phase
    import svpdc_pkg::*;
#(
    parameter int VOLT_WIDTH = VOLT_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VOLT_WIDTH-1:0] alpha_voltage,
    input  logic signed [VOLT_WIDTH-1:0] beta_voltage,
    input  logic [CFG_DATA_W-1:0]        dc_bus,
    input  logic [CFG_DATA_W-1:0]        timer_period,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DIV_W-1:0]             prod_a,
    output logic [DIV_W-1:0]             prod_b,
    output logic [DIV_W-1:0]             prod_c,
    output logic [SECTOR_W-1:0]          sector
);

    // phase voltages in 1/65536 units
    localparam int PW = VOLT_WIDTH + 19;
    localparam int CW = (VOLT_WIDTH + 20 > 34) ? VOLT_WIDTH + 20 : 34;
    localparam int MW = VOLT_WIDTH + 16;
    localparam logic signed [PW-1:0] SQRT3_S = PW'(SQRT3_Q15);
    localparam logic [MW-1:0]        SQRT3_U = MW'(SQRT3_Q15);

    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: inverse clarke, sector terms
    logic signed [PW-1:0] a_ext, b_ext, half_a, b_term;
    logic signed [PW-1:0] pa_next, pb_next, pc_next;
    logic [VOLT_WIDTH-1:0] abs_a, abs_b;
    logic [MW-1:0] lhs_next, rhs_next;
    logic signed [PW-1:0] pa1_reg, pb1_reg, pc1_reg;
    logic [MW-1:0] lhs1_reg, rhs1_reg;
    logic a_neg1_reg, b_neg1_reg;

    // stage 2: min and max, sector
    logic signed [PW-1:0] mx, mn;
    logic signed [PW:0]   sum_next;
    logic [SECTOR_W-1:0]  sector_next;
    logic                 greater;
    logic signed [PW-1:0] pa2_reg, pb2_reg, pc2_reg;
    logic signed [PW:0]   sum2_reg;
    logic [SECTOR_W-1:0]  sector2_reg;

    // stage 3: zero sequence and half bus offset
    logic signed [PW:0]   zs;
    logic signed [CW-1:0] half_bus;
    logic signed [CW-1:0] num_a_next, num_b_next, num_c_next;
    logic signed [CW-1:0] num_a3_reg, num_b3_reg, num_c3_reg;
    logic [SECTOR_W-1:0]  sector3_reg;

    // stage 4: clamp to 0 .. bus
    logic signed [CW-1:0] den_s;
    logic [DIV_W-1:0]     cl_a4_reg, cl_b4_reg, cl_c4_reg;
    logic [SECTOR_W-1:0]  sector4_reg;

    // stage 5: scale by the period
    logic [DIV_W+CMP_W-1:0] mul_a, mul_b, mul_c;
    logic [DIV_W-1:0]       y_a5_reg, y_b5_reg, y_c5_reg;
    logic [SECTOR_W-1:0]    sector5_reg;

    function automatic logic [DIV_W-1:0] clamp_num(
        input logic signed [CW-1:0] num,
        input logic signed [CW-1:0] den
    );
        logic [DIV_W-1:0] r;
        if (num < 0)
            r = '0;
        else if (num > den)
            r = den[DIV_W-1:0];
        else
            r = num[DIV_W-1:0];
        return r;
    endfunction

    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        a_ext   = PW'(alpha_voltage);
        b_ext   = PW'(beta_voltage);
        half_a  = a_ext <<< 15;
        b_term  = b_ext * SQRT3_S;
        pa_next = a_ext <<< 16;
        pb_next = b_term - half_a;
        pc_next = -half_a - b_term;
        abs_a   = alpha_voltage[VOLT_WIDTH-1] ? VOLT_WIDTH'(-alpha_voltage)
                                              : VOLT_WIDTH'(alpha_voltage);
        abs_b   = beta_voltage[VOLT_WIDTH-1] ? VOLT_WIDTH'(-beta_voltage)
                                             : VOLT_WIDTH'(beta_voltage);
        lhs_next = MW'(abs_b) << 15;
        rhs_next = MW'(abs_a) * SQRT3_U;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pa1_reg    <= pa_next;
            pb1_reg    <= pb_next;
            pc1_reg    <= pc_next;
            lhs1_reg   <= lhs_next;
            rhs1_reg   <= rhs_next;
            a_neg1_reg <= alpha_voltage[VOLT_WIDTH-1];
            b_neg1_reg <= beta_voltage[VOLT_WIDTH-1];
        end
    end

    always_comb
    begin
        mx = pa1_reg;
        mn = pa1_reg;
        if (pb1_reg > mx)
            mx = pb1_reg;
        if (pc1_reg > mx)
            mx = pc1_reg;
        if (pb1_reg < mn)
            mn = pb1_reg;
        if (pc1_reg < mn)
            mn = pc1_reg;
        sum_next = (PW+1)'(mx) + (PW+1)'(mn);

        // boundary rays fall to sectors 1, 3, 4 and 6, never to sector 2 or 5
        greater = lhs1_reg > rhs1_reg;
        if (!b_neg1_reg)
            sector_next = greater ? SECTOR_2 : (a_neg1_reg ? SECTOR_3 : SECTOR_1);
        else
            sector_next = greater ? SECTOR_5 : (a_neg1_reg ? SECTOR_4 : SECTOR_6);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            pa2_reg     <= pa1_reg;
            pb2_reg     <= pb1_reg;
            pc2_reg     <= pc1_reg;
            sum2_reg    <= sum_next;
            sector2_reg <= sector_next;
        end
    end

    always_comb
    begin
        // max plus min is always even, so the halving is exact
        zs         = -(sum2_reg >>> 1);
        half_bus   = CW'({dc_bus, 15'b0});
        num_a_next = CW'(pa2_reg) + CW'(zs) + half_bus;
        num_b_next = CW'(pb2_reg) + CW'(zs) + half_bus;
        num_c_next = CW'(pc2_reg) + CW'(zs) + half_bus;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            num_a3_reg  <= num_a_next;
            num_b3_reg  <= num_b_next;
            num_c3_reg  <= num_c_next;
            sector3_reg <= sector2_reg;
        end
    end

    assign den_s = CW'({dc_bus, 16'b0});

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            cl_a4_reg   <= clamp_num(num_a3_reg, den_s);
            cl_b4_reg   <= clamp_num(num_b3_reg, den_s);
            cl_c4_reg   <= clamp_num(num_c3_reg, den_s);
            sector4_reg <= sector3_reg;
        end
    end

    always_comb
    begin
        mul_a = cl_a4_reg * timer_period;
        mul_b = cl_b4_reg * timer_period;
        mul_c = cl_c4_reg * timer_period;
    end

    // dropping the low 16 bits first leaves the final floor unchanged
    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            y_a5_reg    <= mul_a[DIV_W+CMP_W-1:CMP_W];
            y_b5_reg    <= mul_b[DIV_W+CMP_W-1:CMP_W];
            y_c5_reg    <= mul_c[DIV_W+CMP_W-1:CMP_W];
            sector5_reg <= sector4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign prod_a    = y_a5_reg;
    assign prod_b    = y_b5_reg;
    assign prod_c    = y_c5_reg;
    assign sector    = sector5_reg;

endmodule

FILE: rtl/svpdc_div.sv
`timescale 1ns / 1ps

module svpdc_div
    import svpdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIV_W-1:0]      dividend_a,
    input  logic [DIV_W-1:0]      dividend_b,
    input  logic [DIV_W-1:0]      dividend_c,
    input  logic [SECTOR_W-1:0]   sector_in,
    input  logic [CMP_W-1:0]      divisor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CMP_W-1:0]      quot_a,
    output logic [CMP_W-1:0]      quot_b,
    output logic [CMP_W-1:0]      quot_c,
    output logic [SECTOR_W-1:0]   sector_out
);

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] adv;
    div_word_t             word_reg [DIV_STAGES];
    div_word_t             word_in  [DIV_STAGES];
    div_word_t             first_word;

    // one quotient bit per stage; the remainder always stays below the divisor
    function automatic div_lane_t lane_step(
        input div_lane_t        l,
        input logic [CMP_W-1:0] d
    );
        logic [CMP_W:0] trial;
        logic [CMP_W:0] diff;
        div_lane_t      r;
        trial = {l.rem, l.low[CMP_W-1]};
        diff  = trial - {1'b0, d};
        r.low = {l.low[CMP_W-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            r.rem = diff[CMP_W-1:0];
            r.quo = {l.quo[CMP_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[CMP_W-1:0];
            r.quo = {l.quo[CMP_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_word_t word_step(
        input div_word_t        w,
        input logic [CMP_W-1:0] d
    );
        div_word_t r;
        r.lane[0] = lane_step(w.lane[0], d);
        r.lane[1] = lane_step(w.lane[1], d);
        r.lane[2] = lane_step(w.lane[2], d);
        r.sector  = w.sector;
        return r;
    endfunction

    always_comb
    begin
        first_word.lane[0] = '{rem: dividend_a[DIV_W-1:CMP_W], low: dividend_a[CMP_W-1:0],
                               quo: '0};
        first_word.lane[1] = '{rem: dividend_b[DIV_W-1:CMP_W], low: dividend_b[CMP_W-1:0],
                               quo: '0};
        first_word.lane[2] = '{rem: dividend_c[DIV_W-1:CMP_W], low: dividend_c[CMP_W-1:0],
                               quo: '0};
        first_word.sector  = sector_in;
    end

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        if (i == DIV_STAGES - 1)
        begin : g_last
            assign adv[i] = !valid_reg[i] || out_ready;
        end
        else
        begin : g_mid
            assign adv[i] = !valid_reg[i] || adv[i+1];
        end

        if (i == 0)
        begin : g_first
            assign word_in[i] = first_word;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else if (adv[i])
                    valid_reg[i] <= in_valid;
            end
        end
        else
        begin : g_next
            assign word_in[i] = word_reg[i-1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i])
                word_reg[i] <= word_step(word_in[i], divisor);
        end
    end

    assign in_ready   = adv[0];
    assign out_valid  = valid_reg[DIV_STAGES-1];
    assign quot_a     = word_reg[DIV_STAGES-1].lane[0].quo;
    assign quot_b     = word_reg[DIV_STAGES-1].lane[1].quo;
    assign quot_c     = word_reg[DIV_STAGES-1].lane[2].quo;
    assign sector_out = word_reg[DIV_STAGES-1].sector;

endmodule
